>>> rtl/wfe_pkg.sv
// Package for the client WebSocket frame encoder.
// Holds the word types of both channels, the mode codes and the header constants.
// No dependencies.
package wfe_pkg;

    // What an input word carries
    typedef enum logic [0:0]
    {
        MODE_START   = 1'b0,
        MODE_PAYLOAD = 1'b1
    } wfe_mode_t;

    // Input word
    typedef struct packed
    {
        wfe_mode_t   mode;
        logic [31:0] frame_length;
        logic        is_binary;
        logic [31:0] mask_key;
        logic [7:0]  payload_byte;
    } wfe_item_t;

    // Output word
    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       frame_end;
    } wfe_result_t;

    // Header fields
    localparam logic [7:0]  FIN_BIT       = 8'h80;
    localparam logic [7:0]  MASK_BIT      = 8'h80;
    localparam logic [7:0]  OPCODE_TEXT   = 8'h01;
    localparam logic [7:0]  OPCODE_BINARY = 8'h02;
    localparam logic [31:0] LEN7_MAX      = 32'd125;
    localparam logic [31:0] LEN16_MAX     = 32'd65535;
    localparam logic [7:0]  LEN_ESC16     = 8'd126;
    localparam logic [7:0]  LEN_ESC64     = 8'd127;

    // Header sizes in bytes, key included
    localparam int HDR_SLOTS = 16;
    localparam int HDR_CNT_W = $clog2(HDR_SLOTS);
    localparam logic [HDR_CNT_W-1:0] HDR_LEN7  = HDR_CNT_W'(6);
    localparam logic [HDR_CNT_W-1:0] HDR_LEN16 = HDR_CNT_W'(8);
    localparam logic [HDR_CNT_W-1:0] HDR_LEN64 = HDR_CNT_W'(14);

endpackage

>>> rtl/websocket_frame_encoder.sv
// Client WebSocket frame encoder: masked single-fragment frames as a byte stream.
// Depends on wfe_pkg.
//
//  channel | valid/ready              | word                  | accepted when
//  --------+--------------------------+-----------------------+----------------------------
//  input   | item_valid/item_ready    | item (wfe_item_t)     | item_valid && item_ready
//  output  | result_valid/result_ready| result (wfe_result_t) | result_valid && result_ready
//
// A payload word gives at most one byte; payload words stream at one per cycle while
// the output register is free. A start word holds the input register for its 6, 8 or
// 14 header bytes, one per cycle from the header counter while the output is free. A
// payload word with no open frame is dropped without using the output register. The
// output register parts the two sides; a stalled output holds the word and the item
// in progress. Reset clears the frame state, the header counter and both valid flags.
module websocket_frame_encoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  wfe_pkg::wfe_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output wfe_pkg::wfe_result_t result
);

    // Input holding register
    logic                 item_valid_reg, item_valid_next;
    wfe_pkg::wfe_item_t   item_reg, item_next;

    // Frame state
    logic [31:0]          stored_key_reg, stored_key_next;
    logic [31:0]          byte_index_reg, byte_index_next;
    logic [31:0]          stored_length_reg, stored_length_next;
    logic [wfe_pkg::HDR_CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;

    // Output register
    logic                 result_valid_reg, result_valid_next;
    wfe_pkg::wfe_result_t result_reg, result_next;

    // Header build
    logic [7:0]           hdr_bytes [wfe_pkg::HDR_SLOTS];
    logic [wfe_pkg::HDR_CNT_W-1:0] hdr_total;
    logic [7:0]           opcode;
    logic [7:0]           key_byte;

    logic                 slot_free;
    logic                 item_done;
    logic                 emit;
    wfe_pkg::wfe_result_t emit_word;

    // Header bytes of the held start word
    always_comb
    begin
        opcode = item_reg.is_binary ? wfe_pkg::OPCODE_BINARY : wfe_pkg::OPCODE_TEXT;
        for (int i = 0; i < wfe_pkg::HDR_SLOTS; i++)
        begin
            hdr_bytes[i] = 8'h00;
        end
        hdr_bytes[0] = wfe_pkg::FIN_BIT | opcode;
        if (item_reg.frame_length <= wfe_pkg::LEN7_MAX)
        begin
            hdr_total    = wfe_pkg::HDR_LEN7;
            hdr_bytes[1] = wfe_pkg::MASK_BIT | item_reg.frame_length[7:0];
            hdr_bytes[2] = item_reg.mask_key[31:24];
            hdr_bytes[3] = item_reg.mask_key[23:16];
            hdr_bytes[4] = item_reg.mask_key[15:8];
            hdr_bytes[5] = item_reg.mask_key[7:0];
        end
        else if (item_reg.frame_length <= wfe_pkg::LEN16_MAX)
        begin
            hdr_total    = wfe_pkg::HDR_LEN16;
            hdr_bytes[1] = wfe_pkg::MASK_BIT | wfe_pkg::LEN_ESC16;
            hdr_bytes[2] = item_reg.frame_length[15:8];
            hdr_bytes[3] = item_reg.frame_length[7:0];
            hdr_bytes[4] = item_reg.mask_key[31:24];
            hdr_bytes[5] = item_reg.mask_key[23:16];
            hdr_bytes[6] = item_reg.mask_key[15:8];
            hdr_bytes[7] = item_reg.mask_key[7:0];
        end
        else
        begin
            // upper four length bytes stay zero
            hdr_total     = wfe_pkg::HDR_LEN64;
            hdr_bytes[1]  = wfe_pkg::MASK_BIT | wfe_pkg::LEN_ESC64;
            hdr_bytes[6]  = item_reg.frame_length[31:24];
            hdr_bytes[7]  = item_reg.frame_length[23:16];
            hdr_bytes[8]  = item_reg.frame_length[15:8];
            hdr_bytes[9]  = item_reg.frame_length[7:0];
            hdr_bytes[10] = item_reg.mask_key[31:24];
            hdr_bytes[11] = item_reg.mask_key[23:16];
            hdr_bytes[12] = item_reg.mask_key[15:8];
            hdr_bytes[13] = item_reg.mask_key[7:0];
        end
    end

    // Key byte for the current payload position
    always_comb
    begin
        unique case (byte_index_reg[1:0])
            2'd0:    key_byte = stored_key_reg[31:24];
            2'd1:    key_byte = stored_key_reg[23:16];
            2'd2:    key_byte = stored_key_reg[15:8];
            default: key_byte = stored_key_reg[7:0];
        endcase
    end

    // Processing of the held word
    always_comb
    begin
        slot_free          = !result_valid_reg || result_ready;
        item_done          = 1'b0;
        emit               = 1'b0;
        emit_word          = '0;
        stored_key_next    = stored_key_reg;
        byte_index_next    = byte_index_reg;
        stored_length_next = stored_length_reg;
        hdr_cnt_next       = hdr_cnt_reg;

        if (item_valid_reg)
        begin
            if (item_reg.mode == wfe_pkg::MODE_START)
            begin
                if (slot_free)
                begin
                    emit               = 1'b1;
                    emit_word.out_byte = hdr_bytes[hdr_cnt_reg];
                    emit_word.frame_end = (hdr_cnt_reg == hdr_total - 1'b1) &&
                                          (item_reg.frame_length == 32'd0);
                    // open the new frame on the first header byte
                    if (hdr_cnt_reg == '0)
                    begin
                        stored_key_next    = item_reg.mask_key;
                        stored_length_next = item_reg.frame_length;
                        byte_index_next    = 32'd0;
                    end
                    if (hdr_cnt_reg == hdr_total - 1'b1)
                    begin
                        hdr_cnt_next = '0;
                        item_done    = 1'b1;
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end
                end
            end
            else
            begin
                if (byte_index_reg >= stored_length_reg)
                begin
                    // no open frame: drop the word
                    item_done = 1'b1;
                end
                else if (slot_free)
                begin
                    emit                = 1'b1;
                    item_done           = 1'b1;
                    emit_word.out_byte  = item_reg.payload_byte ^ key_byte;
                    emit_word.frame_end = (byte_index_reg + 32'd1) == stored_length_reg;
                    byte_index_next     = byte_index_reg + 32'd1;
                end
            end
        end
    end

    // Handshake and register loads
    always_comb
    begin
        item_ready      = !item_valid_reg || item_done;
        item_valid_next = item_valid_reg;
        item_next       = item_reg;
        if (item_valid && item_ready)
        begin
            item_valid_next = 1'b1;
            item_next       = item;
        end
        else if (item_done)
        begin
            item_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
            result_next       = emit_word;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
            hdr_cnt_reg       <= '0;
            stored_key_reg    <= 32'd0;
            byte_index_reg    <= 32'd0;
            stored_length_reg <= 32'd0;
        end
        else
        begin
            item_valid_reg    <= item_valid_next;
            result_valid_reg  <= result_valid_next;
            hdr_cnt_reg       <= hdr_cnt_next;
            stored_key_reg    <= stored_key_next;
            byte_index_reg    <= byte_index_next;
            stored_length_reg <= stored_length_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Payload position never passes the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= stored_length_reg)
        else $error("byte index beyond frame length");

    // Header counter stays inside the header of the held start word
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && item_reg.mode == wfe_pkg::MODE_START) |-> hdr_cnt_reg < hdr_total)
        else $error("header counter out of range");

    // Counter is idle unless a start word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !(item_valid_reg && item_reg.mode == wfe_pkg::MODE_START) |-> hdr_cnt_reg == '0)
        else $error("header counter busy without start word");

    // A frame end leaves the frame fully sent
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.frame_end) |-> byte_index_reg == stored_length_reg)
        else $error("frame end with payload outstanding");

endmodule

>>> tb/websocket_frame_encoder_tb.sv
// Testbench for websocket_frame_encoder: drives start and payload words, predicts each
// encoded byte with a local frame model and checks every output word against it.
// Depends on wfe_pkg and the websocket_frame_encoder RTL.
module websocket_frame_encoder_tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 250;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 20;

    // Frame model and store of awaited output bytes
    class frame_byte_scoreboard;
        wfe_pkg::wfe_result_t awaited_bytes[$];
        int          errors;
        logic [31:0] frame_key;
        logic [31:0] frame_len;
        logic [31:0] sent_count;

        function new();
            errors     = 0;
            frame_key  = '0;
            frame_len  = '0;
            sent_count = '0;
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            wfe_pkg::wfe_result_t r;
            r.out_byte  = b;
            r.frame_end = last;
            awaited_bytes.insert(awaited_bytes.size(), r);
        endfunction

        // Returns how many bytes the accepted word produces
        function int note_word(wfe_pkg::wfe_item_t w);
            logic [7:0] kb;
            if (w.mode == wfe_pkg::MODE_START)
            begin
                frame_key  = w.mask_key;
                frame_len  = w.frame_length;
                sent_count = '0;
                push_byte(wfe_pkg::FIN_BIT |
                          (w.is_binary ? wfe_pkg::OPCODE_BINARY : wfe_pkg::OPCODE_TEXT), 1'b0);
                if (frame_len <= wfe_pkg::LEN7_MAX)
                    push_byte(wfe_pkg::MASK_BIT | frame_len[7:0], 1'b0);
                else if (frame_len <= wfe_pkg::LEN16_MAX)
                begin
                    push_byte(wfe_pkg::MASK_BIT | wfe_pkg::LEN_ESC16, 1'b0);
                    push_byte(frame_len[15:8], 1'b0);
                    push_byte(frame_len[7:0], 1'b0);
                end
                else
                begin
                    // 64-bit length: upper half always zero
                    push_byte(wfe_pkg::MASK_BIT | wfe_pkg::LEN_ESC64, 1'b0);
                    repeat (4) push_byte(8'h00, 1'b0);
                    push_byte(frame_len[31:24], 1'b0);
                    push_byte(frame_len[23:16], 1'b0);
                    push_byte(frame_len[15:8], 1'b0);
                    push_byte(frame_len[7:0], 1'b0);
                end
                push_byte(frame_key[31:24], 1'b0);
                push_byte(frame_key[23:16], 1'b0);
                push_byte(frame_key[15:8], 1'b0);
                // empty frame ends on the last key byte
                push_byte(frame_key[7:0], frame_len == 32'd0);
                return (frame_len <= wfe_pkg::LEN7_MAX) ? 6 :
                       (frame_len <= wfe_pkg::LEN16_MAX) ? 8 : 14;
            end
            // payload with no open frame is dropped
            if (sent_count >= frame_len)
                return 0;
            case (sent_count[1:0])
                2'd0: kb = frame_key[31:24];
                2'd1: kb = frame_key[23:16];
                2'd2: kb = frame_key[15:8];
                default: kb = frame_key[7:0];
            endcase
            push_byte(w.payload_byte ^ kb, sent_count + 32'd1 == frame_len);
            sent_count = sent_count + 32'd1;
            return 1;
        endfunction

        task report(string what);
            errors++;
            $display("ERROR @%0t: %s", $realtime, what);
        endtask

        task check_word(wfe_pkg::wfe_result_t got);
            wfe_pkg::wfe_result_t want;
            if (awaited_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h end %0b", got.out_byte, got.frame_end));
                return;
            end
            want = awaited_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, predicted %02h", got.out_byte, want.out_byte));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end %0b on byte %02h, predicted %0b",
                                 got.frame_end, got.out_byte, want.frame_end));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    wfe_pkg::wfe_item_t   item;
    logic                 result_valid;
    logic                 result_ready;
    wfe_pkg::wfe_result_t result;

    frame_byte_scoreboard sb = new();
    int cycle_count;
    int items_done;
    int burst_left;
    bit hold_off_req;

    websocket_frame_encoder DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_word(result);
    end

    // Receiver: stall style rotates through four patterns, one long hold-off on request
    initial
    begin
        int rx_cycle;
        int style;
        rx_cycle     = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rx_cycle++;
            style = (rx_cycle / 64) % 4;
            case (style)
                0: result_ready <= 1'b1;
                1: result_ready <= 1'($urandom_range(0, 1));
                2: result_ready <= (rx_cycle % 5) != 0;
                default: result_ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    // Offer one word in bursts; returns at a falling edge with valid still high
    task send_word(wfe_pkg::wfe_item_t w);
        int gap_len;
        if (burst_left == 0)
        begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap_len) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        if (sb.note_word(w) > 0)
            items_done++;
        @(negedge clk);
    endtask

    task send_start(logic [31:0] len, logic bin, logic [31:0] key);
        wfe_pkg::wfe_item_t w;
        w.mode         = wfe_pkg::MODE_START;
        w.frame_length = len;
        w.is_binary    = bin;
        w.mask_key     = key;
        w.payload_byte = 8'($urandom);
        send_word(w);
    endtask

    task send_payload(logic [7:0] b);
        wfe_pkg::wfe_item_t w;
        w.mode         = wfe_pkg::MODE_PAYLOAD;
        w.frame_length = $urandom;
        w.is_binary    = 1'($urandom_range(0, 1));
        w.mask_key     = $urandom;
        w.payload_byte = b;
        send_word(w);
    endtask

    // Stop offering until every predicted byte has come out
    task wait_frames_out();
        item_valid <= 1'b0;
        while (sb.awaited_bytes.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Random frame shapes: complete frames mostly, some cut short, some noise
    task random_frame();
        int pick;
        logic [31:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            len = (pick < 10) ? 0 : (pick < 48) ? $urandom_range(1, 12) : $urandom_range(13, 48);
            send_start(len, 1'($urandom_range(0, 1)), $urandom);
            repeat (len) send_payload(8'($urandom));
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2)) send_payload(8'($urandom));
        end
        else if (pick < 92)
        begin
            // long frame, abandoned by the next start
            if (pick < 76)
                len = ($urandom_range(0, 3) == 0) ? 32'd126 : $urandom_range(126, 65535);
            else
            begin
                len = $urandom;
                if (len <= wfe_pkg::LEN16_MAX)
                    len = len | 32'h0001_0000;
            end
            send_start(len, 1'($urandom_range(0, 1)), $urandom);
            repeat ($urandom_range(0, 6)) send_payload(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
    endtask

    // Main sequence
    initial
    begin
        bit held;
        bit paused;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        hold_off_req = 1'b0;
        items_done   = 0;
        burst_left   = 0;
        held         = 1'b0;
        paused       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: payload before any frame, empty frames, wrap of key index
        send_payload(8'hFF);
        send_start(32'd0, 1'b0, 32'h0000_0000);
        send_start(32'd0, 1'b1, 32'hFFFF_FFFF);
        send_payload(8'h00);
        send_start(32'd1, 1'b1, 32'hA5A5_A5A5);
        send_payload(8'hFF);
        send_start(32'd5, 1'b0, 32'h0123_4567);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h3C);
        send_payload(8'hC3);
        send_payload(8'h5A);
        send_payload(8'h77);
        // Length escapes at their boundaries, each left open and abandoned, then a complete short frame
        send_start(32'd125, 1'b1, 32'hDEAD_BEEF);
        send_payload(8'h12);
        send_start(32'd126, 1'b0, 32'h8001_0080);
        send_payload(8'h80);
        send_start(32'd65535, 1'b1, 32'h5555_AAAA);
        send_start(32'd65536, 1'b0, 32'hAAAA_5555);
        send_payload(8'h01);
        send_start(32'hFFFF_FFFF, 1'b1, 32'h7F7F_7F7F);
        send_payload(8'hFE);
        send_start(32'd3, 1'b0, 32'hC0DE_F00D);
        send_payload(8'h01);
        send_payload(8'h02);
        send_payload(8'h03);
        wait_frames_out();

        // Random part
        items_done = 0;
        while (items_done < RANDOM_WORDS)
        begin
            if (!held && items_done >= 90)
            begin
                hold_off_req = 1'b1;
                held         = 1'b1;
            end
            if (!paused && items_done >= 180)
            begin
                wait_frames_out();
                paused = 1'b1;
            end
            random_frame();
        end
        wait_frames_out();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.awaited_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
